// File: rtl/cubic_bezier_segment_sampler_macros.svh
// ----------------------------------------------------------------------------
// Cubic Bezier segment sampler: assertion macros
// Same-cycle and next-cycle implication checks, compiled out by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_SEGMENT_SAMPLER_MACROS_SVH
`define CUBIC_BEZIER_SEGMENT_SAMPLER_MACROS_SVH
`ifndef ASSERT_OFF
`define CBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbs: same-cycle check failed");
`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbs: next-cycle check failed");
`else
`define CBS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/cbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier segment sampler: package
// Field widths, control-point types, saturation and Bernstein weight table.
// ----------------------------------------------------------------------------
package cbs_pkg;

    localparam int TIME_W    = 31;
    localparam int POS_W     = 32;
    localparam int IDX_W     = 6;
    localparam int TF_W      = 16;
    localparam int RT_W      = 2;
    localparam int N_SEG_DEF = 32;

    localparam logic [TF_W-1:0] TF_RESET = 16'd26214;

    localparam logic [RT_W-1:0] REQ_USE_END   = 2'b01;
    localparam logic [RT_W-1:0] REQ_USE_START = 2'b10;

    // control point time, control point position, unsaturated position sum
    localparam int CT_W  = 33;
    localparam int CP_W  = 40;
    localparam int CPS_W = 49;
    // Bernstein weight, divider input, divider range, quotient
    localparam int W_W   = 18;
    localparam int X_W   = 61;
    localparam int DIV_L = 50;
    localparam int Q_W   = 32;

    localparam logic signed [CPS_W-1:0] CP_LIM  = 49'sd549755813887;
    localparam logic signed [CPS_W-1:0] CP_NLIM = -CP_LIM;

    typedef struct packed {
        logic [RT_W-1:0]   rt;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t3;
        logic [POS_W-1:0]  p0;
        logic [POS_W-1:0]  p3;
        logic [POS_W-1:0]  ss;
        logic [POS_W-1:0]  es;
    } t_seg;

    typedef struct packed {
        logic [3:0][CT_W-1:0] t;
        logic [3:0][CP_W-1:0] p;
    } t_cps;

    typedef logic [3:0][W_W-1:0] t_wrow;
    typedef t_wrow [2**IDX_W-1:0] t_wtab;

    function automatic logic [CP_W-1:0] sat_cp(input logic signed [CPS_W-1:0] v);
        logic [CP_W-1:0] res;
        if (v > CP_LIM) begin
            res = CP_LIM[CP_W-1:0];
        end else if (v < CP_NLIM) begin
            res = CP_NLIM[CP_W-1:0];
        end else begin
            res = v[CP_W-1:0];
        end
        return res;
    endfunction

    function automatic t_wtab build_wtab(input int n);
        t_wtab tab;
        int    r;
        tab = '0;
        for (int i = 0; i < 2**IDX_W; i++) begin
            if (i <= n) begin
                r = n - i;
                tab[i][0] = W_W'(r * r * r);
                tab[i][1] = W_W'(3 * r * r * i);
                tab[i][2] = W_W'(3 * r * i * i);
                tab[i][3] = W_W'(i * i * i);
            end
        end
        return tab;
    endfunction

endpackage

// File: rtl/cbs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier segment sampler: channel interfaces
// Segment request channel and sample result channel, valid/ready.
// ----------------------------------------------------------------------------
interface cbs_seg_if;
    logic                                valid;
    logic                                ready;
    logic [cbs_pkg::RT_W-1:0]            req_type;
    logic [cbs_pkg::TIME_W-1:0]          start_time;
    logic signed [cbs_pkg::POS_W-1:0]    start_pos;
    logic [cbs_pkg::TIME_W-1:0]          end_time;
    logic signed [cbs_pkg::POS_W-1:0]    end_pos;
    logic signed [cbs_pkg::POS_W-1:0]    start_slope;
    logic signed [cbs_pkg::POS_W-1:0]    end_slope;

    modport source (
        output valid, req_type, start_time, start_pos, end_time, end_pos,
               start_slope, end_slope,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_time, start_pos, end_time, end_pos,
               start_slope, end_slope,
        output ready
    );
endinterface

interface cbs_smp_if;
    logic                                valid;
    logic                                ready;
    logic [cbs_pkg::TIME_W-1:0]          sample_time;
    logic signed [cbs_pkg::POS_W-1:0]    sample_pos;
    logic [cbs_pkg::IDX_W-1:0]           sample_index;
    logic                                last_sample;

    modport source (
        output valid, sample_time, sample_pos, sample_index, last_sample,
        input  ready
    );
    modport sink (
        input  valid, sample_time, sample_pos, sample_index, last_sample,
        output ready
    );
endinterface

// File: rtl/cubic_bezier_segment_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier segment sampler
// Path: control point pipeline, sample generator, product and sum registers,
// dividers, output register. Throughput: one sample per cycle while the
// output is not stalled; the generator issues one curve parameter per cycle.
// Reset: synchronous, active low; flushes all stages, tangent_fraction 26214.
// ----------------------------------------------------------------------------
`include "cubic_bezier_segment_sampler_macros.svh"

module cubic_bezier_segment_sampler #(
    parameter int N_SEG = cbs_pkg::N_SEG_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cbs_pkg::TF_W-1:0]  i_cfg_wdata,
    cbs_seg_if.sink                   i_seg,
    cbs_smp_if.source                 o_smp
);

    localparam int unsigned DEN  = N_SEG * N_SEG * N_SEG;
    localparam int          X_W  = cbs_pkg::X_W;
    localparam int          IDX_W = cbs_pkg::IDX_W;
    localparam int          PT_W = 52;
    localparam int          PP_W = 59;
    localparam int          ST_W = 53;
    localparam int          SP_W = 60;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_SEG);
    localparam logic [X_W-1:0]   X_RND_T  = X_W'(DEN / 2);
    localparam logic [X_W-1:0]   X_RND_P  = X_W'(DEN / 2) + (X_W'(DEN) << 31);
    localparam cbs_pkg::t_wtab   WTAB     = cbs_pkg::build_wtab(N_SEG);

    logic [cbs_pkg::TF_W-1:0] r_tf;

    logic                w_f_valid;
    cbs_pkg::t_cps       w_f_cps;
    logic                w_en, w_g_done, w_g_take;

    logic                r_g_valid;
    logic [IDX_W-1:0]    r_g_cnt;
    cbs_pkg::t_cps       r_g_cps;

    logic                r_p1_valid, r_p2_valid, r_p3_valid, r_p4_valid;
    cbs_pkg::t_wrow      r_p1_w;
    cbs_pkg::t_cps       r_p1_cps;
    logic [IDX_W-1:0]    r_p1_idx, r_p2_idx, r_p3_idx, r_p4_idx;
    logic                r_p1_last, r_p2_last, r_p3_last, r_p4_last;
    logic signed [PT_W-1:0] n_pt [4];
    logic signed [PP_W-1:0] n_pp [4];
    logic signed [PT_W-1:0] r_p2_pt [4];
    logic signed [PP_W-1:0] r_p2_pp [4];
    logic signed [ST_W-1:0] r_p3_t01, r_p3_t23;
    logic signed [SP_W-1:0] r_p3_p01, r_p3_p23;
    logic [X_W-1:0]      r_p4_xt, r_p4_xp;

    logic [IDX_W-1:0]    r_d_idx [3];
    logic [2:0]          r_d_last;
    logic                w_dt_valid, w_dp_valid;
    logic [cbs_pkg::Q_W-1:0] w_qt, w_qp;

    logic                r_o_valid;
    logic [cbs_pkg::TIME_W-1:0] r_o_time;
    logic [cbs_pkg::POS_W-1:0]  r_o_pos;
    logic [IDX_W-1:0]    r_o_idx;
    logic                r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tf <= cbs_pkg::TF_RESET;
        end else if (i_cfg_we) begin
            r_tf <= i_cfg_wdata;
        end
    end

    cbs_cpts u_cpts (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tf    (r_tf),
        .i_seg   (i_seg),
        .i_take  (w_g_take),
        .o_valid (w_f_valid),
        .o_cps   (w_f_cps)
    );

    assign w_en     = !r_o_valid || o_smp.ready;
    assign w_g_done = r_g_valid && w_en && (r_g_cnt == LAST_IDX);
    assign w_g_take = w_f_valid && (!r_g_valid || w_g_done);

    // sample generator: one curve parameter per advancing cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_g_cnt   <= '0;
        end else if (w_g_take) begin
            r_g_valid <= 1'b1;
            r_g_cnt   <= '0;
        end else if (w_g_done) begin
            r_g_valid <= 1'b0;
        end else if (r_g_valid && w_en) begin
            r_g_cnt   <= r_g_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_g_take) begin
            r_g_cps <= w_f_cps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_en) begin
            r_p1_valid <= r_g_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
            r_o_valid  <= w_dt_valid;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_pt[k] = $signed({1'b0, r_p1_w[k]}) * $signed(r_p1_cps.t[k]);
            n_pp[k] = $signed({1'b0, r_p1_w[k]}) * $signed(r_p1_cps.p[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_w    <= WTAB[r_g_cnt];
            r_p1_cps  <= r_g_cps;
            r_p1_idx  <= r_g_cnt;
            r_p1_last <= (r_g_cnt == LAST_IDX);

            for (int k = 0; k < 4; k++) begin
                r_p2_pt[k] <= n_pt[k];
                r_p2_pp[k] <= n_pp[k];
            end
            r_p2_idx  <= r_p1_idx;
            r_p2_last <= r_p1_last;

            r_p3_t01  <= ST_W'(r_p2_pt[0]) + ST_W'(r_p2_pt[1]);
            r_p3_t23  <= ST_W'(r_p2_pt[2]) + ST_W'(r_p2_pt[3]);
            r_p3_p01  <= SP_W'(r_p2_pp[0]) + SP_W'(r_p2_pp[1]);
            r_p3_p23  <= SP_W'(r_p2_pp[2]) + SP_W'(r_p2_pp[3]);
            r_p3_idx  <= r_p2_idx;
            r_p3_last <= r_p2_last;

            r_p4_xt   <= X_W'(r_p3_t01) + X_W'(r_p3_t23) + X_RND_T;
            r_p4_xp   <= X_W'(r_p3_p01) + X_W'(r_p3_p23) + X_RND_P;
            r_p4_idx  <= r_p3_idx;
            r_p4_last <= r_p3_last;

            r_d_idx[0] <= r_p4_idx;
            r_d_idx[1] <= r_d_idx[0];
            r_d_idx[2] <= r_d_idx[1];
            r_d_last   <= {r_d_last[1:0], r_p4_last};

            r_o_time <= w_qt[cbs_pkg::Q_W-1] ? {cbs_pkg::TIME_W{1'b1}}
                                             : w_qt[cbs_pkg::TIME_W-1:0];
            r_o_pos  <= {~w_qp[cbs_pkg::Q_W-1], w_qp[cbs_pkg::Q_W-2:0]};
            r_o_idx  <= r_d_idx[2];
            r_o_last <= r_d_last[2];
        end
    end

    cbs_cdiv #(
        .N_SEG (N_SEG)
    ) u_div_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p4_valid),
        .i_x     (r_p4_xt),
        .o_valid (w_dt_valid),
        .o_q     (w_qt)
    );

    cbs_cdiv #(
        .N_SEG (N_SEG)
    ) u_div_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p4_valid),
        .i_x     (r_p4_xp),
        .o_valid (w_dp_valid),
        .o_q     (w_qp)
    );

    assign o_smp.valid        = r_o_valid;
    assign o_smp.sample_time  = r_o_time;
    assign o_smp.sample_pos   = r_o_pos;
    assign o_smp.sample_index = r_o_idx;
    assign o_smp.last_sample  = r_o_last;

    `CBS_ASSERT_SAME(a_div_lockstep, i_clk, i_rst_n, 1'b1, w_dt_valid == w_dp_valid)
    `CBS_ASSERT_SAME(a_gen_range, i_clk, i_rst_n, r_g_valid, r_g_cnt <= LAST_IDX)
    `CBS_ASSERT_SAME(a_last_flag, i_clk, i_rst_n, o_smp.valid, o_smp.last_sample == (o_smp.sample_index == LAST_IDX))
    `CBS_ASSERT_NEXT(a_burst, i_clk, i_rst_n, o_smp.valid && o_smp.ready && !o_smp.last_sample, o_smp.valid && (o_smp.sample_index == $past(o_smp.sample_index) + 6'd1))

endmodule

// File: rtl/cbs_cpts.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier segment sampler: control point pipeline
// Six stages from a segment to the four control points, p1 and p2 saturated.
// ----------------------------------------------------------------------------
module cbs_cpts (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [cbs_pkg::TF_W-1:0]  i_tf,
    cbs_seg_if.sink                   i_seg,
    input  logic                      i_take,
    output logic                      o_valid,
    output cbs_pkg::t_cps             o_cps
);

    logic [5:0]          r_vld;
    logic                w_adv;

    cbs_pkg::t_seg       n_seg;
    logic signed [31:0]  n_dt;
    cbs_pkg::t_seg       r_f1_seg, r_f2_seg, r_f3_seg, r_f4_seg, r_f5_seg;
    logic signed [31:0]  r_f1_dt;
    logic signed [48:0]  r_f2_prod;
    logic signed [48:0]  n_f2_rnd;
    logic signed [31:0]  r_f3_off;
    logic signed [32:0]  r_f4_t1, r_f4_t2, r_f5_t1, r_f5_t2;
    logic signed [63:0]  r_f4_psp, r_f4_pep;
    logic signed [63:0]  n_psr, n_per;
    logic signed [47:0]  r_f5_ps, r_f5_pe;
    logic signed [48:0]  n_p1s, n_p2s;
    cbs_pkg::t_cps       n_cps, r_f6_cps;

    function automatic logic signed [48:0] CPS_EXT(input logic [31:0] v);
        return 49'($signed(v));
    endfunction

    assign w_adv       = !r_vld[5] || i_take;
    assign i_seg.ready = w_adv;
    assign o_valid     = r_vld[5];
    assign o_cps       = r_f6_cps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[4:0], i_seg.valid};
        end
    end

    always_comb begin
        n_seg.rt = i_seg.req_type;
        n_seg.t0 = i_seg.start_time;
        n_seg.t3 = i_seg.end_time;
        n_seg.p0 = i_seg.start_pos;
        n_seg.p3 = i_seg.end_pos;
        n_seg.ss = i_seg.start_slope;
        n_seg.es = i_seg.end_slope;
        n_dt     = $signed({1'b0, i_seg.end_time}) - $signed({1'b0, i_seg.start_time});
    end

    always_comb begin
        n_f2_rnd = r_f2_prod + 49'sd32768;
        n_psr    = r_f4_psp + 64'sd32768;
        n_per    = r_f4_pep + 64'sd32768;
        n_p1s    = CPS_EXT(r_f5_seg.p0) + 49'(r_f5_ps);
        n_p2s    = CPS_EXT(r_f5_seg.p3) - 49'(r_f5_pe);

        n_cps.t[0] = {2'b00, r_f5_seg.t0};
        n_cps.t[1] = r_f5_t1;
        n_cps.t[2] = r_f5_t2;
        n_cps.t[3] = {2'b00, r_f5_seg.t3};
        n_cps.p[0] = cbs_pkg::CP_W'($signed(r_f5_seg.p0));
        n_cps.p[3] = cbs_pkg::CP_W'($signed(r_f5_seg.p3));
        if ((r_f5_seg.rt & cbs_pkg::REQ_USE_START) != '0) begin
            n_cps.p[1] = cbs_pkg::sat_cp(n_p1s);
        end else begin
            n_cps.p[1] = cbs_pkg::CP_W'($signed(r_f5_seg.p0));
        end
        if ((r_f5_seg.rt & cbs_pkg::REQ_USE_END) != '0) begin
            n_cps.p[2] = cbs_pkg::sat_cp(n_p2s);
        end else begin
            n_cps.p[2] = cbs_pkg::CP_W'($signed(r_f5_seg.p3));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_seg  <= n_seg;
            r_f1_dt   <= n_dt;
            r_f2_seg  <= r_f1_seg;
            r_f2_prod <= r_f1_dt * $signed({1'b0, i_tf});
            r_f3_seg  <= r_f2_seg;
            r_f3_off  <= n_f2_rnd[47:16];
            r_f4_seg  <= r_f3_seg;
            r_f4_t1   <= $signed({2'b00, r_f3_seg.t0}) + 33'(r_f3_off);
            r_f4_t2   <= $signed({2'b00, r_f3_seg.t3}) - 33'(r_f3_off);
            r_f4_psp  <= r_f3_off * $signed(r_f3_seg.ss);
            r_f4_pep  <= r_f3_off * $signed(r_f3_seg.es);
            r_f5_seg  <= r_f4_seg;
            r_f5_t1   <= r_f4_t1;
            r_f5_t2   <= r_f4_t2;
            r_f5_ps   <= n_psr[63:16];
            r_f5_pe   <= n_per[63:16];
            r_f6_cps  <= n_cps;
        end
    end

endmodule

// File: rtl/cbs_cdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier segment sampler: constant divider
// Floor of x / N_SEG^3 by reciprocal multiply, clamped to 0 .. 2^32-1.
// ----------------------------------------------------------------------------
module cbs_cdiv #(
    parameter int N_SEG = cbs_pkg::N_SEG_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [cbs_pkg::X_W-1:0]  i_x,
    output logic                     o_valid,
    output logic [cbs_pkg::Q_W-1:0]  o_q
);

    localparam int unsigned DEN   = N_SEG * N_SEG * N_SEG;
    localparam int          L     = cbs_pkg::DIV_L;
    localparam int          K     = L + $clog2(DEN);
    localparam int          XL_W  = 25;
    localparam int          XH_W  = L - XL_W;
    localparam int          ML_W  = 26;
    localparam int          MH_W  = 26;
    localparam int          PP_W  = 51;
    localparam int          MID_W = 78;
    localparam int          TOT_W = 102;
    localparam logic [127:0] MAGIC =
        ((128'd1 << K) + 128'(DEN) - 128'd1) / 128'(DEN);
    localparam logic [MH_W-1:0] M_HI = MAGIC[ML_W +: MH_W];
    localparam logic [ML_W-1:0] M_LO = MAGIC[ML_W-1:0];
    localparam logic [cbs_pkg::X_W-1:0] X_LIM = cbs_pkg::X_W'(DEN) << cbs_pkg::Q_W;

    logic [2:0]              r_v;
    logic                    r_d1_neg, r_d1_ovf, r_d2_neg, r_d2_ovf;
    logic [PP_W-1:0]         r_hh, r_hl, r_lh, r_ll, r_d2_hh, r_d2_ll;
    logic [MID_W-1:0]        r_mid;
    logic [TOT_W-1:0]        n_tot;
    logic [XH_W-1:0]         w_xh;
    logic [XL_W-1:0]         w_xl;
    logic [cbs_pkg::Q_W-1:0] r_q;

    assign w_xh    = i_x[L-1:XL_W];
    assign w_xl    = i_x[XL_W-1:0];
    assign o_valid = r_v[2];
    assign o_q     = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_comb begin
        n_tot = (TOT_W'(r_d2_hh) << (XL_W + ML_W)) + TOT_W'(r_mid) + TOT_W'(r_d2_ll);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1_neg <= i_x[cbs_pkg::X_W-1];
            r_d1_ovf <= !i_x[cbs_pkg::X_W-1] && (i_x >= X_LIM);
            r_hh     <= w_xh * M_HI;
            r_hl     <= w_xh * M_LO;
            r_lh     <= w_xl * M_HI;
            r_ll     <= w_xl * M_LO;

            r_d2_neg <= r_d1_neg;
            r_d2_ovf <= r_d1_ovf;
            r_d2_hh  <= r_hh;
            r_d2_ll  <= r_ll;
            r_mid    <= (MID_W'(r_hl) << XL_W) + (MID_W'(r_lh) << ML_W);

            if (r_d2_neg) begin
                r_q <= '0;
            end else if (r_d2_ovf) begin
                r_q <= '1;
            end else begin
                r_q <= n_tot[K +: cbs_pkg::Q_W];
            end
        end
    end

endmodule
